// File: hw/rtl/string_escape_decoder_assert.svh
// Assertion macros shared by the string escape decoder modules.
`ifndef STRING_ESCAPE_DECODER_ASSERT_SVH
`define STRING_ESCAPE_DECODER_ASSERT_SVH

// Plain property, checked on every rising clock edge outside reset.
`define SED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sed_pkg.sv
// Types and constants of the string escape decoder.
package sed_pkg;

  localparam int CHAR_W    = 21;
  localparam int ACC_W     = 32;
  localparam int DIGIT_W   = 4;
  localparam int OUT_DEPTH = 8;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = PTR_W + 2;

  localparam logic [CHAR_W-1:0] QUOTE_RESET = CHAR_W'(34);
  localparam logic [ACC_W-1:0]  CP_MAX      = ACC_W'(32'h10FFFF);
  localparam logic [ACC_W-1:0]  SURR_LO     = ACC_W'(32'hD800);
  localparam logic [ACC_W-1:0]  SURR_HI     = ACC_W'(32'hE000);
  localparam logic [ACC_W-1:0]  CP_REPLACE  = ACC_W'(32'hFFFD);
  localparam logic [ACC_W-1:0]  BYTE_MAX    = ACC_W'(255);

  typedef enum logic [1:0] {
    KIND_VALUE,
    KIND_QUOTE,
    KIND_EOF,
    KIND_NEWLINE
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_UNKNOWN,
    ERR_NOT_HEX,
    ERR_NOT_OCT,
    ERR_BAD_CP,
    ERR_OCT_RANGE
  } err_e;

  // One result word.
  typedef struct packed {
    logic [CHAR_W-1:0] value;
    logic              is_byte;
    kind_e             kind;
    err_e              err;
    logic              last;
  } result_t;

  // Results of one decoded character, handed to the output queue.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// File: hw/rtl/sed_in_if.sv
// Input channel: one source character per word.
interface sed_in_if import sed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              at_eof;

  modport source (output valid, output char_in, output at_eof, input ready);
  modport sink (input valid, input char_in, input at_eof, output ready);
endinterface

// File: hw/rtl/sed_out_if.sv
// Output channel: one decoded result per word.
interface sed_out_if import sed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] value;
  logic              is_byte;
  logic [1:0]        result_kind;
  logic [2:0]        error_code;
  logic              last;

  modport source (output valid, output value, output is_byte, output result_kind,
                  output error_code, output last, input ready);
  modport sink (input valid, input value, input is_byte, input result_kind,
                input error_code, input last, output ready);
endinterface

// File: hw/rtl/string_escape_decoder.sv
// Top level of the string escape decoder.
//
// Characters of a string or rune literal arrive on in_i, one word per
// character, with at_eof marking the end of input. Decoded results leave on
// out_o; a character gives zero, one or two result words, and the final word
// of each character carries last.
// The quote register is written through cfg_we_i and cfg_data_i; the user
// must do so only while the block is idle, which the block does not enforce.
// An accepted word passes through the input register and then the result
// queue before its first result word appears on out_o.
// Throughput is one character per cycle while in_i.ready is high; the escape
// state is updated for each character, so characters follow back to back.
// A character with two results leaves as two words on the one-word-wide port.
// The result queue holds eight words. When the receiver stalls, the queue
// fills and in_i.ready drops as soon as there may be no room for two more
// characters of two results each; nothing is lost.
// Reset clears the escape state, the valid bit of the input register and
// the queue, and returns the quote register to the double quote.
module string_escape_decoder import sed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CHAR_W-1:0] cfg_data_i,
  sed_in_if.sink            in_i,
  sed_out_if.source         out_o
);

  logic [CHAR_W-1:0] quote_q;
  logic              busy;
  logic              take;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  committed;
  push_t             push;

  // Quote register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q <= QUOTE_RESET;
    end else if (cfg_we_i) begin
      quote_q <= cfg_data_i;
    end
  end

  // Accept only while the queue can absorb the registered word and a new one.
  assign committed  = count + (busy ? CNT_W'(2) : CNT_W'(0));
  assign in_i.ready = (committed <= CNT_W'(OUT_DEPTH - 4));
  assign take       = in_i.valid && in_i.ready;

  sed_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .char_i (in_i.char_in),
    .eof_i  (in_i.at_eof),
    .quote_i(quote_q),
    .busy_o (busy),
    .push_o (push)
  );

  sed_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .count_o(count),
    .out_o  (out_o)
  );

endmodule

// File: hw/rtl/sed_decode.sv
// Input register, escape state machine and result generation.
`include "string_escape_decoder_assert.svh"

module sed_decode import sed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic              eof_i,
  input  logic [CHAR_W-1:0] quote_i,
  output logic              busy_o,
  output push_t             push_o
);

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_HEX   = 2'd2;
  localparam logic [1:0] MODE_OCT   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_NL = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] CH_BS = CHAR_W'("\\");

  logic              valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              eof_q;
  logic [1:0]        mode_q, mode_d;
  logic [DIGIT_W-1:0] digits_q, digits_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              uni_q, uni_d;
  logic              byte_q, byte_d;

  result_t           plain_res;
  logic              plain_emit;
  logic              plain_esc;
  logic              hex_ok;
  logic [3:0]        hex_val;
  logic              oct_ok;
  logic [ACC_W-1:0]  hex_acc;
  logic [ACC_W-1:0]  oct_acc;
  push_t             push;

  function automatic result_t mk(logic [CHAR_W-1:0] v, logic b, kind_e k, err_e e);
    result_t r;
    r.value   = v;
    r.is_byte = b;
    r.kind    = k;
    r.err     = e;
    r.last    = 1'b0;
    return r;
  endfunction

  // End of a hex escape; Unicode forms replace invalid code points.
  function automatic result_t hex_done(logic [ACC_W-1:0] v, logic uni, logic byt, err_e e);
    logic [ACC_W-1:0] val;
    err_e             er;
    val = v;
    er  = e;
    if (uni && ((v > CP_MAX) || ((v >= SURR_LO) && (v < SURR_HI)))) begin
      val = CP_REPLACE;
      if (e == ERR_NONE) begin
        er = ERR_BAD_CP;
      end
    end
    return mk(val[CHAR_W-1:0], byt, KIND_VALUE, er);
  endfunction

  // End of an octal escape; values above a byte are flagged but kept.
  function automatic result_t oct_done(logic [ACC_W-1:0] v, err_e e);
    err_e er;
    er = e;
    if ((e == ERR_NONE) && (v > BYTE_MAX)) begin
      er = ERR_OCT_RANGE;
    end
    return mk(v[CHAR_W-1:0], 1'b1, KIND_VALUE, er);
  endfunction

  // Input register and escape state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      mode_q   <= MODE_PLAIN;
      digits_q <= '0;
      acc_q    <= '0;
      uni_q    <= 1'b0;
      byte_q   <= 1'b0;
    end else begin
      valid_q  <= take_i;
      mode_q   <= mode_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
      uni_q    <= uni_d;
      byte_q   <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      char_q <= char_i;
      eof_q  <= eof_i;
    end
  end

  // Handling of a character outside any escape.
  always_comb begin
    plain_res  = mk(char_q, 1'b0, KIND_VALUE, ERR_NONE);
    plain_emit = 1'b1;
    plain_esc  = 1'b0;
    if (eof_q) begin
      plain_res = mk('0, 1'b0, KIND_EOF, ERR_NONE);
    end else if (char_q == CH_NL) begin
      plain_res = mk('0, 1'b0, KIND_NEWLINE, ERR_NONE);
    end else if (char_q == CH_BS) begin
      plain_emit = 1'b0;
      plain_esc  = 1'b1;
    end else if (char_q == quote_i) begin
      plain_res = mk('0, 1'b0, KIND_QUOTE, ERR_NONE);
    end
  end

  // Digit classification and accumulator updates.
  always_comb begin
    hex_ok  = 1'b0;
    hex_val = char_q[3:0];
    if ((char_q >= CHAR_W'("0")) && (char_q <= CHAR_W'("9"))) begin
      hex_ok = 1'b1;
    end else if (((char_q >= CHAR_W'("a")) && (char_q <= CHAR_W'("f"))) ||
                 ((char_q >= CHAR_W'("A")) && (char_q <= CHAR_W'("F")))) begin
      hex_ok  = 1'b1;
      hex_val = char_q[3:0] + 4'd9;
    end
    hex_ok  = hex_ok && !eof_q;
    oct_ok  = !eof_q && (char_q >= CHAR_W'("0")) && (char_q <= CHAR_W'("7"));
    hex_acc = {acc_q[ACC_W-5:0], hex_val};
    oct_acc = {acc_q[ACC_W-4:0], char_q[2:0]};
  end

  // Next state and results of the registered character.
  always_comb begin
    mode_d   = mode_q;
    digits_d = digits_q;
    acc_d    = acc_q;
    uni_d    = uni_q;
    byte_d   = byte_q;
    push.n   = 2'd0;
    push.r0  = plain_res;
    push.r1  = plain_res;
    if (valid_q) begin
      unique case (mode_q)
        MODE_PLAIN: begin
          push.n = {1'b0, plain_emit};
          if (plain_esc) begin
            mode_d = MODE_ESC;
          end
        end
        MODE_ESC: begin
          mode_d = MODE_PLAIN;
          push.n = 2'd1;
          if (eof_q) begin
            push.n  = 2'd2;
            push.r0 = mk('0, 1'b0, KIND_VALUE, ERR_UNKNOWN);
            push.r1 = mk('0, 1'b0, KIND_EOF, ERR_NONE);
          end else begin
            unique case (char_q)
              CHAR_W'("x"), CHAR_W'("u"), CHAR_W'("U"): begin
                push.n = 2'd0;
                mode_d = MODE_HEX;
                acc_d  = '0;
                uni_d  = (char_q != CHAR_W'("x"));
                byte_d = (char_q == CHAR_W'("x"));
                if (char_q == CHAR_W'("x")) begin
                  digits_d = DIGIT_W'(2);
                end else if (char_q == CHAR_W'("u")) begin
                  digits_d = DIGIT_W'(4);
                end else begin
                  digits_d = DIGIT_W'(8);
                end
              end
              CHAR_W'("a"):  push.r0 = mk(CHAR_W'(7), 1'b0, KIND_VALUE, ERR_NONE);
              CHAR_W'("b"):  push.r0 = mk(CHAR_W'(8), 1'b0, KIND_VALUE, ERR_NONE);
              CHAR_W'("f"):  push.r0 = mk(CHAR_W'(12), 1'b0, KIND_VALUE, ERR_NONE);
              CHAR_W'("n"):  push.r0 = mk(CHAR_W'(10), 1'b0, KIND_VALUE, ERR_NONE);
              CHAR_W'("r"):  push.r0 = mk(CHAR_W'(13), 1'b0, KIND_VALUE, ERR_NONE);
              CHAR_W'("t"):  push.r0 = mk(CHAR_W'(9), 1'b0, KIND_VALUE, ERR_NONE);
              CHAR_W'("v"):  push.r0 = mk(CHAR_W'(11), 1'b0, KIND_VALUE, ERR_NONE);
              CH_BS:         push.r0 = mk(CH_BS, 1'b0, KIND_VALUE, ERR_NONE);
              default: begin
                if (oct_ok) begin
                  push.n   = 2'd0;
                  mode_d   = MODE_OCT;
                  digits_d = DIGIT_W'(2);
                  acc_d    = ACC_W'(char_q[2:0]);
                  uni_d    = 1'b0;
                  byte_d   = 1'b1;
                end else if (char_q == quote_i) begin
                  push.r0 = mk(char_q, 1'b0, KIND_VALUE, ERR_NONE);
                end else begin
                  push.r0 = mk(char_q, 1'b0, KIND_VALUE, ERR_UNKNOWN);
                end
              end
            endcase
          end
        end
        MODE_HEX: begin
          if (hex_ok) begin
            acc_d = hex_acc;
            if (digits_q <= DIGIT_W'(1)) begin
              digits_d = '0;
              mode_d   = MODE_PLAIN;
              push.n   = 2'd1;
              push.r0  = hex_done(hex_acc, uni_q, byte_q, ERR_NONE);
            end else begin
              digits_d = digits_q - DIGIT_W'(1);
            end
          end else begin
            // The bad digit ends the escape and is then taken as plain text.
            push.r0 = hex_done(acc_q, uni_q, byte_q, ERR_NOT_HEX);
            push.n  = plain_emit ? 2'd2 : 2'd1;
            mode_d  = plain_esc ? MODE_ESC : MODE_PLAIN;
          end
        end
        MODE_OCT: begin
          if (oct_ok) begin
            acc_d = oct_acc;
            if (digits_q <= DIGIT_W'(1)) begin
              digits_d = '0;
              mode_d   = MODE_PLAIN;
              push.n   = 2'd1;
              push.r0  = oct_done(oct_acc, ERR_NONE);
            end else begin
              digits_d = digits_q - DIGIT_W'(1);
            end
          end else begin
            push.r0 = oct_done(acc_q, ERR_NOT_OCT);
            push.n  = plain_emit ? 2'd2 : 2'd1;
            mode_d  = plain_esc ? MODE_ESC : MODE_PLAIN;
          end
        end
        default: begin
          mode_d = MODE_PLAIN;
        end
      endcase
    end
    // Mark the final result of this character.
    push.r0.last = (push.n == 2'd1);
    push.r1.last = (push.n == 2'd2);
  end

  assign push_o = push;
  assign busy_o = valid_q;

  `SED_ASSERT_NXT(a_backslash_enters_escape,
    valid_q && (mode_q == MODE_PLAIN) && !eof_q && (char_q == CH_BS),
    mode_q == MODE_ESC, "backslash did not enter escape mode")
  `SED_ASSERT_IMP(a_digits_pending, (mode_q == MODE_HEX) || (mode_q == MODE_OCT),
    digits_q != '0, "digit mode with no digits left")
  `SED_ASSERT_IMP(a_idle_no_push, !valid_q, push.n == 2'd0,
    "results pushed without a character")

endmodule

// File: hw/rtl/sed_out_fifo.sv
// Result queue: takes up to two results a cycle, pops one if ready.
`include "string_escape_decoder_assert.svh"

module sed_out_fifo import sed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  output logic [CNT_W-1:0] count_o,
  sed_out_if.source        out_o
);

  result_t           mem_q [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              pop;
  result_t           head;

  assign pop      = (count_q != '0) && out_o.ready;
  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_i.n);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign count_d  = count_q + CNT_W'(push_i.n) - CNT_W'(pop);

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage; the second result goes one slot after the first.
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.r1;
    end
  end

  assign head              = mem_q[rd_ptr_q];
  assign out_o.valid       = (count_q != '0);
  assign out_o.value       = head.value;
  assign out_o.is_byte     = head.is_byte;
  assign out_o.result_kind = head.kind;
  assign out_o.error_code  = head.err;
  assign out_o.last        = head.last;
  assign count_o           = count_q;

  `SED_ASSERT(a_no_overflow, count_q <= CNT_W'(OUT_DEPTH), "result queue overflow")
  `SED_ASSERT_NXT(a_double_push, (push_i.n == 2'd2) && !pop,
    count_q == $past(count_q) + CNT_W'(2), "double push miscounted")

endmodule

// File: test/tb.sv
// Self-checking testbench for the string escape decoder with a scoreboard class.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = CHAR_W'(92);
  localparam logic [CHAR_W-1:0] CH_DQUOTE    = CHAR_W'(34);
  localparam logic [CHAR_W-1:0] CH_SQUOTE    = CHAR_W'(39);
  localparam logic [CHAR_W-1:0] CH_TOP       = CHAR_W'(21'h10FFFF);
  localparam logic [31:0] MAX_CODE        = 32'h10FFFF;
  localparam logic [31:0] SURROGATE_FIRST = 32'hD800;
  localparam logic [31:0] SURROGATE_END   = 32'hE000;
  localparam logic [31:0] REPLACEMENT     = 32'hFFFD;
  localparam logic [31:0] BYTE_TOP        = 32'd255;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int SEGMENTS      = 9;
  localparam int SEGMENT_ITEMS = 180;

  typedef enum logic [1:0] {
    SCAN_PLAIN,
    SCAN_ESCAPE,
    SCAN_HEX,
    SCAN_OCTAL
  } scan_e;

  typedef struct {
    logic [CHAR_W-1:0] c;
    bit                eof;
  } src_char_t;

  // Tracks the decoder state and holds the result words still to arrive.
  class escape_decode_checker;
    logic [CHAR_W-1:0] quote;
    scan_e             mode;
    logic [3:0]        digits_left;
    logic [31:0]       acc;
    bit                unicode_form;
    bit                byte_form;
    result_t           pending_words[$];
    int                mismatches;

    function new();
      quote        = CH_DQUOTE;
      mode         = SCAN_PLAIN;
      digits_left  = '0;
      acc          = '0;
      unicode_form = 1'b0;
      byte_form    = 1'b0;
      mismatches   = 0;
    endfunction

    static function int hex_value(logic [CHAR_W-1:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void add(logic [31:0] v, bit b, kind_e k, err_e e);
      result_t r;
      r.value   = v[CHAR_W-1:0];
      r.is_byte = b;
      r.kind    = k;
      r.err     = e;
      r.last    = 1'b0;
      pending_words.push_back(r);
    endfunction

    function void begin_digits(scan_e m, logic [3:0] n, logic [31:0] a, bit u, bit b);
      mode         = m;
      digits_left  = n;
      acc          = a;
      unicode_form = u;
      byte_form    = b;
    endfunction

    // Character outside any escape: terminators, backslash, quote or a value.
    function void plain(logic [CHAR_W-1:0] c, bit eof);
      if (eof) add(0, 1'b0, KIND_EOF, ERR_NONE);
      else if (c == CH_NEWLINE) add(0, 1'b0, KIND_NEWLINE, ERR_NONE);
      else if (c == CH_BACKSLASH) mode = SCAN_ESCAPE;
      else if (c == quote) add(0, 1'b0, KIND_QUOTE, ERR_NONE);
      else add(32'(c), 1'b0, KIND_VALUE, ERR_NONE);
    endfunction

    // Unicode escapes replace surrogates and values past the top code point.
    function void close_hex(err_e e);
      logic [31:0] v;
      v = acc;
      if (unicode_form && (v > MAX_CODE || (v >= SURROGATE_FIRST && v < SURROGATE_END))) begin
        v = REPLACEMENT;
        if (e == ERR_NONE) e = ERR_BAD_CP;
      end
      mode = SCAN_PLAIN;
      add(v, byte_form, KIND_VALUE, e);
    endfunction

    function void close_octal(err_e e);
      if (e == ERR_NONE && acc > BYTE_TOP) e = ERR_OCT_RANGE;
      mode = SCAN_PLAIN;
      add(acc, 1'b1, KIND_VALUE, e);
    endfunction

    // Works out the result words of one accepted source character.
    function void note_char(logic [CHAR_W-1:0] c, bit eof);
      int      before_cnt;
      int      d;
      result_t r;
      before_cnt = pending_words.size();
      case (mode)
        SCAN_PLAIN: plain(c, eof);
        SCAN_ESCAPE: begin
          mode = SCAN_PLAIN;
          if (eof) begin
            add(0, 1'b0, KIND_VALUE, ERR_UNKNOWN);
            add(0, 1'b0, KIND_EOF, ERR_NONE);
          end else begin
            case (c)
              "x": begin_digits(SCAN_HEX, 4'd2, 0, 1'b0, 1'b1);
              "u": begin_digits(SCAN_HEX, 4'd4, 0, 1'b1, 1'b0);
              "U": begin_digits(SCAN_HEX, 4'd8, 0, 1'b1, 1'b0);
              "a": add(7, 1'b0, KIND_VALUE, ERR_NONE);
              "b": add(8, 1'b0, KIND_VALUE, ERR_NONE);
              "f": add(12, 1'b0, KIND_VALUE, ERR_NONE);
              "n": add(10, 1'b0, KIND_VALUE, ERR_NONE);
              "r": add(13, 1'b0, KIND_VALUE, ERR_NONE);
              "t": add(9, 1'b0, KIND_VALUE, ERR_NONE);
              "v": add(11, 1'b0, KIND_VALUE, ERR_NONE);
              CH_BACKSLASH: add(92, 1'b0, KIND_VALUE, ERR_NONE);
              default: begin
                if (c >= "0" && c <= "7")
                  begin_digits(SCAN_OCTAL, 4'd2, 32'(c - "0"), 1'b0, 1'b1);
                else
                  add(32'(c), 1'b0, KIND_VALUE, (c == quote) ? ERR_NONE : ERR_UNKNOWN);
              end
            endcase
          end
        end
        SCAN_HEX: begin
          d = eof ? -1 : hex_value(c);
          if (d >= 0) begin
            acc = (acc << 4) + 32'(d);
            if (digits_left <= 4'd1) begin
              digits_left = '0;
              close_hex(ERR_NONE);
            end else begin
              digits_left = digits_left - 4'd1;
            end
          end else begin
            // The bad digit ends the escape and is then taken as a plain character.
            close_hex(ERR_NOT_HEX);
            plain(c, eof);
          end
        end
        default: begin
          if (!eof && c >= "0" && c <= "7") begin
            acc = (acc << 3) + 32'(c - "0");
            if (digits_left <= 4'd1) begin
              digits_left = '0;
              close_octal(ERR_NONE);
            end else begin
              digits_left = digits_left - 4'd1;
            end
          end else begin
            close_octal(ERR_NOT_OCT);
            plain(c, eof);
          end
        end
      endcase
      if (pending_words.size() > before_cnt) begin
        r = pending_words.pop_back();
        r.last = 1'b1;
        pending_words.push_back(r);
      end
    endfunction

    // Compares one accepted result word with the oldest pending one.
    function void check_word(result_t got);
      result_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing pending: value %h byte %b kind %0d err %0d last %b",
                   $realtime, got.value, got.is_byte, got.kind, got.err, got.last);
        return;
      end
      want = pending_words.pop_front();
      if (got.value !== want.value || got.is_byte !== want.is_byte || got.kind !== want.kind ||
          got.err !== want.err || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch: expected value %h byte %b kind %0d err %0d last %b",
                   $realtime, want.value, want.is_byte, want.kind, want.err, want.last);
          $display("%0t:           got      value %h byte %b kind %0d err %0d last %b",
                   $realtime, got.value, got.is_byte, got.kind, got.err, got.last);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CHAR_W-1:0]   cfg_data;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  int                  cycles;
  logic [CHAR_W-1:0]   cur_quote;
  result_t             seen_word;
  src_char_t           script[$];
  escape_decode_checker chk;

  sed_in_if  in_if ();
  sed_out_if out_if ();

  string_escape_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls at the current rate.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) chk.note_char(in_if.char_in, in_if.at_eof);
      if (out_if.valid && out_if.ready) begin
        seen_word.value   = out_if.value;
        seen_word.is_byte = out_if.is_byte;
        seen_word.kind    = kind_e'(out_if.result_kind);
        seen_word.err     = err_e'(out_if.error_code);
        seen_word.last    = out_if.last;
        chk.check_word(seen_word);
      end
    end
  end

  function automatic void push(logic [CHAR_W-1:0] c, bit eof = 1'b0);
    src_char_t s;
    s.c   = c;
    s.eof = eof;
    script.push_back(s);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_any();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return CHAR_W'($urandom_range(126, 32));
      5, 6:          return CHAR_W'($urandom_range(255, 0));
      default:       return CHAR_W'($urandom_range(32'h10FFFF, 0));
    endcase
  endfunction

  // Character that cannot continue the current digit run.
  function automatic logic [CHAR_W-1:0] pick_stop(bit octal);
    logic [CHAR_W-1:0] c;
    do c = pick_any();
    while (octal ? (c >= "0" && c <= "7") : (escape_decode_checker::hex_value(c) >= 0));
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CHAR_W'("0") + CHAR_W'(n);
    if ($urandom_range(1)) return CHAR_W'("a") + CHAR_W'(n - 4'd10);
    return CHAR_W'("A") + CHAR_W'(n - 4'd10);
  endfunction

  // Code point for a Unicode escape, aimed at the range edges.
  function automatic logic [31:0] pick_code(bit wide);
    case ($urandom_range(5))
      0: return $urandom_range(32'hD7FF, 0);
      1: return $urandom_range(32'hDFFF, 32'hD800);
      2: return $urandom_range(32'hFFFF, 32'hE000);
      3: return wide ? $urandom_range(32'h10FFFF, 32'h10000) : $urandom_range(255, 0);
      4: return wide ? $urandom() : 32'hFFFF;
      default: return wide ? $urandom_range(32'h11FFFF, 32'h110000) : 32'h0;
    endcase
  endfunction

  // Ends a digit run early with a bad character or the end of input.
  function automatic void push_stop(bit octal);
    if ($urandom_range(4) == 0) push(pick_any(), 1'b1);
    else push(pick_stop(octal));
  endfunction

  function automatic void push_hex(logic [7:0] letter, int n, logic [31:0] v);
    int keep;
    push(CH_BACKSLASH);
    push(CHAR_W'(letter));
    keep = ($urandom_range(4) == 0) ? $urandom_range(n - 1, 0) : n;
    for (int i = n - 1; i >= n - keep; i--) push(hex_char(v[4*i +: 4]));
    if (keep < n) push_stop(1'b0);
  endfunction

  // Appends one piece of a literal: mostly well-formed escapes, some noise.
  function automatic void push_piece();
    int                sel;
    int                keep;
    logic [CHAR_W-1:0] c;
    logic [7:0]        simple[8];
    simple = '{"a", "b", "f", "n", "r", "t", "v", 8'd92};
    sel = $urandom_range(99);
    if (sel < 30) begin
      do c = pick_any();
      while (c == CH_BACKSLASH);
      push(c);
    end else if (sel < 38) begin
      push(CH_BACKSLASH);
      if ($urandom_range(8) == 0) push(cur_quote);
      else push(CHAR_W'(simple[$urandom_range(7)]));
    end else if (sel < 44) begin
      push(CH_BACKSLASH);
      push(pick_any());
    end else if (sel < 54) begin
      push_hex("x", 2, $urandom_range(255, 0));
    end else if (sel < 64) begin
      push_hex("u", 4, pick_code(1'b0));
    end else if (sel < 74) begin
      push_hex("U", 8, pick_code(1'b1));
    end else if (sel < 84) begin
      push(CH_BACKSLASH);
      keep = ($urandom_range(4) == 0) ? $urandom_range(2, 1) : 3;
      for (int i = 0; i < keep; i++) push(CHAR_W'("0") + CHAR_W'($urandom_range(7)));
      if (keep < 3) push_stop(1'b1);
    end else if (sel < 88) begin
      push(cur_quote);
    end else if (sel < 92) begin
      push(CH_NEWLINE);
    end else if (sel < 95) begin
      push(pick_any(), 1'b1);
    end else if (sel < 97) begin
      push(CH_BACKSLASH);
      push(pick_any(), 1'b1);
    end else begin
      push(CHAR_W'($urandom_range(32'h10FFFF, 0)));
    end
  endfunction

  // Offers one word on the input channel; called and returning at a falling edge.
  task automatic send_char(logic [CHAR_W-1:0] c, bit eof);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.char_in <= c;
    in_if.at_eof  <= eof;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_script(inout int sent);
    src_char_t s;
    while (script.size() != 0) begin
      s = script.pop_front();
      send_char(s.c, s.eof);
      sent++;
    end
  endtask

  // Holds the input off until every expected word is out, then lets the block settle.
  task automatic wait_idle(int settle);
    in_if.valid <= 1'b0;
    while (chk.pending_words.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_quote(logic [CHAR_W-1:0] q);
    cfg_we   <= 1'b1;
    cfg_data <= q;
    @(negedge clk);
    cfg_we    <= 1'b0;
    chk.quote = q;
    cur_quote = q;
  endtask

  initial begin
    logic [CHAR_W-1:0] quotes[SEGMENTS];
    int                sent;
    bit                paused;

    in_if.valid   = 1'b0;
    in_if.char_in = '0;
    in_if.at_eof  = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    rst_n         = 1'b0;
    tx_idle_pct   = 24;
    rx_idle_pct   = 60;
    cur_quote     = CH_DQUOTE;
    chk           = new();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part with the reset quote: extremes, terminators and a selection of escape forms.
    sent = 0;
    push(CH_TOP);
    push('0);
    push(CH_DQUOTE);
    push(CH_NEWLINE);
    push(CHAR_W'(21'h155555), 1'b1);
    push(CH_BACKSLASH); push("n");
    push(CH_BACKSLASH); push("q");
    push(CH_BACKSLASH); push(CH_DQUOTE);
    push(CH_BACKSLASH); push("7"); push("7"); push("7");
    push(CH_BACKSLASH); push("u"); push("d"); push("8"); push("0"); push("0");
    push(CH_BACKSLASH); push("x"); push("4"); push("z");
    push(CH_BACKSLASH); push("1"); push("9");
    push(CH_BACKSLASH); push(CH_TOP, 1'b1);
    send_script(sent);

    // Random part in segments with their own quotes; each three share idle rates.
    quotes = '{CH_SQUOTE, '0, CH_TOP, CH_NEWLINE, CH_BACKSLASH, CHAR_W'("n"),
               CHAR_W'("7"), CHAR_W'($urandom_range(32'h10FFFF, 0)), CH_DQUOTE};
    paused = 1'b0;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle(DRAIN_CYCLES);
      write_quote(quotes[seg]);
      case (seg / 3)
        0: begin tx_idle_pct = 24; rx_idle_pct = 60; end
        1: begin tx_idle_pct = 60; rx_idle_pct = 24; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        push_piece();
        send_script(sent);
        if (seg == 4 && !paused && sent >= SEGMENT_ITEMS / 2) begin
          paused = 1'b1;
          wait_idle(1);
        end
      end
    end

    wait_idle(20);
    if (chk.mismatches == 0 && chk.pending_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sed_pkg.sv
hw/rtl/sed_in_if.sv
hw/rtl/sed_out_if.sv
hw/rtl/sed_decode.sv
hw/rtl/sed_out_fifo.sv
hw/rtl/string_escape_decoder.sv
test/tb.sv
